FILE: hw/rtl/obl_pkg.sv
// ----------------------------------------------------------------------------
// Ordered byte list engine package
// Item types, request and status codes, cell commands and control states
// shared by the list cells and the top level.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int unsigned REQ_W     = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned OUT_CNT_W = 5;

  // Request codes carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_DELETE     = 3'd5,
    REQ_READ       = 3'd6
  } req_code_t;

  // Status codes returned with every result item
  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_RANGE     = 3'd4
  } status_code_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_INSERT,
    CELL_DELETE,
    CELL_SCAN_START,
    CELL_SCAN_STEP
  } cell_op_t;

  // Control states of the top level
  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] key;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  position;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [BYTE_W-1:0]    data_out;
  } rsp_item_t;

  typedef struct packed {
    cell_op_t          op;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] key;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/obl_cell.sv
// ----------------------------------------------------------------------------
// Ordered byte list cell
// Holds one list entry and one step of the key search token; shifts its
// byte to or from its neighbors as the broadcast command directs.
// ----------------------------------------------------------------------------
module obl_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  obl_pkg::cell_cmd_t          cmd,
  input  logic [CW-1:0]               count,
  input  logic [IW-1:0]               sel,
  input  logic [obl_pkg::BYTE_W-1:0]  prev_val,
  input  logic [obl_pkg::BYTE_W-1:0]  next_val,
  input  logic                        prev_tok,
  output logic [obl_pkg::BYTE_W-1:0]  val_o,
  output logic                        tok_o,
  output logic                        live_o,
  output logic                        stop_o,
  output logic [obl_pkg::BYTE_W-1:0]  rd_o
);
  import obl_pkg::*;

  logic [BYTE_W-1:0] val_r, val_nxt;
  logic              tok_r, tok_nxt;
  logic              pass_r, pass_nxt;
  logic              occupied;

  // Entry is part of the list when its place is below the count
  assign occupied = CW'(IDX) < count;

  assign val_o  = val_r;
  assign tok_o  = tok_r;
  assign live_o = tok_r & occupied;
  assign stop_o = tok_r & occupied & (val_r == cmd.key);
  assign rd_o   = (sel == IW'(IDX)) ? val_r : '0;

  // Shift the entry for pushes, pop front, inserts and deletes
  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      CELL_PUSH_FRONT: val_nxt = (IDX == 0) ? cmd.data : prev_val;
      CELL_PUSH_BACK:  val_nxt = (count == CW'(IDX)) ? cmd.data : val_r;
      CELL_POP_FRONT:  val_nxt = next_val;
      CELL_INSERT: begin
        if (prev_tok) begin
          val_nxt = cmd.data;
        end else if (!pass_r && !tok_r) begin
          val_nxt = prev_val;
        end
      end
      CELL_DELETE: begin
        if (!pass_r) begin
          val_nxt = next_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  // Advance the search token one cell per cycle, marking cells it leaves
  always_comb begin
    tok_nxt  = tok_r;
    pass_nxt = pass_r;
    case (cmd.op)
      CELL_SCAN_START: begin
        tok_nxt  = (IDX == 0);
        pass_nxt = 1'b0;
      end
      CELL_SCAN_STEP: begin
        tok_nxt  = prev_tok;
        pass_nxt = pass_r | tok_r;
      end
      default: begin
        tok_nxt  = tok_r;
        pass_nxt = pass_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      pass_r <= 1'b0;
    end else begin
      tok_r  <= tok_nxt;
      pass_r <= pass_nxt;
    end
  end

endmodule

FILE: hw/rtl/ordered_byte_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered byte list engine
// Ordered list of up to DEPTH bytes kept in a chain of cells, front at cell 0.
// ----------------------------------------------------------------------------
// Usage: send one request per item on in_valid/in_ready (push front, push
// back, insert after key, pop front, pop back, delete key, read position).
// Each item returns exactly one result item on out_valid/out_ready with a
// status, the entry count after the request and the byte popped or read.
// Pushes, pops and reads finish in the cycle they are accepted; the result
// is registered and appears the next cycle, so these run one item per cycle
// while the receiver takes each result. Insert (list not full) and delete
// (list not empty) walk a search token down the cell chain one cell per
// cycle; on a match or at the end of the list the result is loaded and the
// block returns to idle; no new item is taken during the walk.
// Reset empties the list and clears the output valid flag; stored bytes are
// not cleared. A new item is accepted while a result waits in the output
// register only if that register empties in the same cycle; while the
// receiver stalls the result holds and no further item is taken.
// ----------------------------------------------------------------------------
module ordered_byte_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  obl_pkg::req_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output obl_pkg::rsp_item_t out_data
);
  import obl_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  fsm_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ins_r;
  logic [BYTE_W-1:0] key_r;
  logic [BYTE_W-1:0] value_r;
  logic              out_valid_r;
  rsp_item_t         out_data_r;

  cell_cmd_t         cmd;
  rsp_item_t         rsp_nxt;
  logic              load_out;
  logic              out_free;
  logic              accept;
  logic              full;
  logic              empty;
  logic              found;
  logic              missing;
  logic              start_scan;
  logic [IW-1:0]     sel;
  logic [BYTE_W-1:0] rd_data;

  logic [BYTE_W-1:0] val_w [DEPTH];
  logic [BYTE_W-1:0] rd_w  [DEPTH];
  logic [DEPTH-1:0]  tok_w;
  logic [DEPTH-1:0]  live_w;
  logic [DEPTH-1:0]  stop_w;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [BYTE_W-1:0] prev_val;
    logic [BYTE_W-1:0] next_val;
    logic              prev_tok;

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_tok = 1'b0;
    end else begin : g_body
      assign prev_val = val_w[i-1];
      assign prev_tok = tok_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = val_w[i];
    end else begin : g_link
      assign next_val = val_w[i+1];
    end

    obl_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .count    (count_r),
      .sel      (sel),
      .prev_val (prev_val),
      .next_val (next_val),
      .prev_tok (prev_tok),
      .val_o    (val_w[i]),
      .tok_o    (tok_w[i]),
      .live_o   (live_w[i]),
      .stop_o   (stop_w[i]),
      .rd_o     (rd_w[i])
    );
  end

  // Gather the selected byte from the chain
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | rd_w[i];
    end
  end

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign found    = |stop_w;
  assign missing  = ~|live_w;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == FSM_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign start_scan = ((in_data.req_type == REQ_INSERT) && !full) ||
                      ((in_data.req_type == REQ_DELETE) && !empty);

  // Pick the cell to read: front, back or requested position
  always_comb begin
    case (in_data.req_type)
      REQ_POP_FRONT: sel = '0;
      REQ_POP_BACK:  sel = IW'(count_r - 1'b1);
      default:       sel = IW'(in_data.position);
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept && start_scan) begin
          state_nxt = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (found || missing) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Cell command, count update and result
  always_comb begin
    cmd.op           = CELL_HOLD;
    cmd.data         = in_data.value;
    cmd.key          = key_r;
    count_nxt        = count_r;
    load_out         = 1'b0;
    rsp_nxt.status   = STS_OK;
    rsp_nxt.data_out = '0;
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              load_out = 1'b1;
              if (full) begin
                rsp_nxt.status = STS_FULL;
              end else begin
                cmd.op    = (in_data.req_type == REQ_PUSH_FRONT) ?
                            CELL_PUSH_FRONT : CELL_PUSH_BACK;
                count_nxt = count_r + 1'b1;
              end
            end
            REQ_INSERT: begin
              if (full) begin
                load_out       = 1'b1;
                rsp_nxt.status = STS_FULL;
              end else begin
                cmd.op = CELL_SCAN_START;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              load_out = 1'b1;
              if (empty) begin
                rsp_nxt.status = STS_EMPTY;
              end else begin
                if (in_data.req_type == REQ_POP_FRONT) begin
                  cmd.op = CELL_POP_FRONT;
                end
                rsp_nxt.data_out = rd_data;
                count_nxt        = count_r - 1'b1;
              end
            end
            REQ_DELETE: begin
              if (empty) begin
                load_out       = 1'b1;
                rsp_nxt.status = STS_EMPTY;
              end else begin
                cmd.op = CELL_SCAN_START;
              end
            end
            REQ_READ: begin
              load_out = 1'b1;
              if (empty) begin
                rsp_nxt.status = STS_EMPTY;
              end else if (CMPW'(in_data.position) >= CMPW'(count_r)) begin
                rsp_nxt.status = STS_RANGE;
              end else begin
                rsp_nxt.data_out = rd_data;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      FSM_SCAN: begin
        cmd.data = value_r;
        if (found) begin
          load_out = 1'b1;
          if (ins_r) begin
            cmd.op    = CELL_INSERT;
            count_nxt = count_r + 1'b1;
          end else begin
            cmd.op    = CELL_DELETE;
            count_nxt = count_r - 1'b1;
          end
        end else if (missing) begin
          load_out       = 1'b1;
          rsp_nxt.status = STS_NOT_FOUND;
        end else begin
          cmd.op = CELL_SCAN_STEP;
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
    rsp_nxt.entry_count = OUT_CNT_W'(count_nxt);
  end

  // Hold the search request while the token walks, and register the result
  always_ff @(posedge clk) begin
    if (accept) begin
      ins_r   <= (in_data.req_type == REQ_INSERT);
      key_r   <= in_data.key;
      value_r <= in_data.value;
    end
    if (load_out) begin
      out_data_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: verif/ordered_byte_list_engine_tb.sv
// ----------------------------------------------------------------------------
// Ordered byte list engine testbench
// Drives push, insert, pop, delete and read requests through the valid/ready
// request channel. It keeps its own copy of the list, predicts each result
// item on acceptance and compares every returned item field by field, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module ordered_byte_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obl_pkg::*;

  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned CHUNK_ITEMS = 40;
  localparam int unsigned NUM_CHUNKS  = 32;
  localparam int unsigned CALM_CHUNKS = 6;
  localparam int unsigned DRAIN_WAIT  = 40;
  // Request code left unused by the block; it must be ignored
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  req_item_t in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rsp_item_t out_data;

  req_item_t   req_backlog[$];
  rsp_item_t   answers_due[$];
  logic [7:0]  list_bytes[$];
  logic [7:0]  byte_pool[8];
  bit          idle_en = 1'b1;
  int          gap_left = 0;
  int          stall_left = 0;
  int          err_count = 0;
  int unsigned cycle_count = 0;

  ordered_byte_list_engine #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Index of the first held byte equal to the key, -1 when absent
  function automatic int find_byte(logic [7:0] key);
    for (int i = 0; i < list_bytes.size(); i++) begin
      if (list_bytes[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the list copy and return the answer it gives
  function automatic rsp_item_t apply_to_list(req_item_t r);
    rsp_item_t rsp;
    int        idx;
    rsp = '0;
    rsp.status = STS_OK;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (list_bytes.size() >= LIST_DEPTH) begin
          rsp.status = STS_FULL;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          list_bytes.push_front(r.value);
        end else if (r.req_type == REQ_PUSH_BACK) begin
          list_bytes.push_back(r.value);
        end else begin
          idx = find_byte(r.key);
          if (idx < 0) rsp.status = STS_NOT_FOUND;
          else list_bytes.insert(idx + 1, r.value);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (list_bytes.size() == 0) rsp.status = STS_EMPTY;
        else if (r.req_type == REQ_POP_FRONT) rsp.data_out = list_bytes.pop_front();
        else rsp.data_out = list_bytes.pop_back();
      end
      REQ_DELETE: begin
        if (list_bytes.size() == 0) begin
          rsp.status = STS_EMPTY;
        end else begin
          idx = find_byte(r.key);
          if (idx < 0) rsp.status = STS_NOT_FOUND;
          else list_bytes.delete(idx);
        end
      end
      REQ_READ: begin
        if (list_bytes.size() == 0) rsp.status = STS_EMPTY;
        else if (r.position >= list_bytes.size()) rsp.status = STS_RANGE;
        else rsp.data_out = list_bytes[r.position];
      end
      default: begin
      end
    endcase
    rsp.entry_count = OUT_CNT_W'(list_bytes.size());
    return rsp;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Compare a returned item against the oldest prediction
  function automatic void check_answer(rsp_item_t got);
    rsp_item_t want;
    if (answers_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      err_count++;
      return;
    end
    want = answers_due.pop_front();
    check_field("status", int'(want.status), int'(got.status));
    check_field("entry_count", int'(want.entry_count), int'(got.entry_count));
    check_field("data_out", int'(want.data_out), int'(got.data_out));
  endfunction

  task automatic queue_req(logic [REQ_W-1:0] op, logic [7:0] key, logic [7:0] value,
                           logic [POS_W-1:0] pos);
    req_item_t r;
    r.req_type = op;
    r.key      = key;
    r.value    = value;
    r.position = pos;
    req_backlog.push_back(r);
  endtask

  // Mostly pool bytes so keys hit often; grow_pct biases toward growing
  function automatic req_item_t random_request(int grow_pct);
    req_item_t r;
    r.key      = ($urandom_range(0, 4) != 0) ? byte_pool[$urandom_range(0, 7)]
                                             : 8'($urandom);
    r.value    = ($urandom_range(0, 4) != 0) ? byte_pool[$urandom_range(0, 7)]
                                             : 8'($urandom);
    r.position = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 2) begin
      r.req_type = REQ_UNUSED;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       r.req_type = REQ_PUSH_FRONT;
        1:       r.req_type = REQ_PUSH_BACK;
        default: r.req_type = REQ_INSERT;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       r.req_type = REQ_POP_FRONT;
        1:       r.req_type = REQ_POP_BACK;
        2:       r.req_type = REQ_DELETE;
        default: r.req_type = REQ_READ;
      endcase
    end
    return r;
  endfunction

  // Hold until every request is accepted and every answer has come back
  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || answers_due.size() != 0)
      @(negedge clk);
  endtask

  // Request driver: predict on acceptance, then present the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) answers_due.push_back(apply_to_list(in_data));
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_en && req_backlog.size() != 0 && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) check_answer(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_byte_list_engine test failed");
      $finish;
    end
  end

  initial begin
    // Empty list: every removal and lookup reports empty, unused code ignored
    queue_req(REQ_POP_FRONT, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_POP_BACK, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_DELETE, 8'hFF, 8'h00, 4'd0);
    queue_req(REQ_READ, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_INSERT, 8'h00, 8'hFF, 4'd0);
    queue_req(REQ_UNUSED, 8'hFF, 8'hFF, 4'd15);
    // Build, insert after last entry, miss, read the extremes
    queue_req(REQ_PUSH_FRONT, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_PUSH_BACK, 8'h00, 8'hFF, 4'd0);
    queue_req(REQ_INSERT, 8'hFF, 8'hA5, 4'd0);
    queue_req(REQ_INSERT, 8'h00, 8'h5A, 4'd0);
    queue_req(REQ_INSERT, 8'h33, 8'h11, 4'd0);
    queue_req(REQ_READ, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_READ, 8'h00, 8'h00, 4'd3);
    queue_req(REQ_READ, 8'h00, 8'h00, 4'd15);
    // Delete hit and miss, then pop down through a one-entry list
    queue_req(REQ_DELETE, 8'h5A, 8'h00, 4'd0);
    queue_req(REQ_DELETE, 8'h77, 8'h00, 4'd0);
    queue_req(REQ_POP_BACK, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_POP_FRONT, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_POP_FRONT, 8'h00, 8'h00, 4'd0);
    queue_req(REQ_READ, 8'h00, 8'h00, 4'd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    wait_drained();

    // Random chunks alternating growth, drain and mixed traffic
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      for (int p = 0; p < 8; p++) byte_pool[p] = 8'($urandom);
      if (c == NUM_CHUNKS - CALM_CHUNKS) idle_en = 1'b0;
      if (c == NUM_CHUNKS / 3) wait_drained();
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        case (c % 3)
          0:       req_backlog.push_back(random_request(80));
          1:       req_backlog.push_back(random_request(25));
          default: req_backlog.push_back(random_request(50));
        endcase
      end
      while (req_backlog.size() > 8) @(negedge clk);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("ordered_byte_list_engine test passed");
    end else begin
      $display("ordered_byte_list_engine test failed");
    end
    $finish;
  end

endmodule

FILE: ordered_byte_list_engine.f
hw/rtl/obl_pkg.sv
hw/rtl/obl_cell.sv
hw/rtl/ordered_byte_list_engine.sv
verif/ordered_byte_list_engine_tb.sv
